// ===== src/rrsp_pkg.sv =====
package rrsp_pkg;

    localparam int CNT_W      = 11;
    localparam int REC_PORT_W = 64;
    localparam int OP_W       = 3;
    localparam int TIME_W     = 32;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_PEEK     = 3'd1,
        OP_POP      = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_MAINTAIN = 3'd4,
        OP_FLUSH    = 3'd5
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_REMOVE = 2'd2
    } t_act;

    localparam logic [CFG_IDX_W-1:0] CFG_DROP_OLDEST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL = 2'd1;

    localparam logic              DROP_OLDEST_RST    = 1'b1;
    localparam logic [TIME_W-1:0] FLUSH_INTERVAL_RST = 32'd300000;

endpackage

// ===== src/rrsp_if.sv =====
interface rrsp_in_if;
    logic                               valid;
    logic                               ready;
    logic [rrsp_pkg::OP_W-1:0]          operation;
    logic [rrsp_pkg::REC_PORT_W-1:0]    record;
    logic [rrsp_pkg::CNT_W-1:0]         offset;
    logic [rrsp_pkg::TIME_W-1:0]        now_ms;

    modport source (output valid, output operation, output record, output offset,
                    output now_ms, input ready);
    modport sink   (input valid, input operation, input record, input offset,
                    input now_ms, output ready);
endinterface

interface rrsp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [rrsp_pkg::REC_PORT_W-1:0]    read_record;
    logic [rrsp_pkg::CNT_W-1:0]         fill_count;
    logic [rrsp_pkg::ACT_W-1:0]         snapshot_action;

    modport source (output valid, output ok, output read_record, output fill_count,
                    output snapshot_action, input ready);
    modport sink   (input valid, input ok, input read_record, input fill_count,
                    input snapshot_action, output ready);
endinterface

interface rrsp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rrsp_pkg::CFG_IDX_W-1:0]     index;
    logic [rrsp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/rrsp_store.sv =====
module rrsp_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/record_ring_with_snapshot_policy_unit.sv =====
// Record ring with snapshot policy.
//
// i_in carries one operation per beat (push, peek, pop, clear, maintain,
// flush now) with its record, offset and millisecond timestamp. o_out returns
// exactly one result beat per input beat: ok, the peeked record, the fill
// count after the operation and the snapshot command. i_cfg writes the
// drop_oldest mode (index 0) and the flush interval (index 1); it is always
// ready and should only be used while no operation is in flight.
//
// The ring state updates at the accepting edge and the result register,
// together with the registered read port of the record memory, presents
// the result in the following cycle. One beat per cycle is sustained while
// o_out is ready: the result register refills in the cycle it is taken, and
// each operation uses at most one access to the memory's write or read port.
//
// Reset empties the ring and restores the register defaults; memory content
// is not cleared, so no clearing pass is needed. When o_out stalls the result
// register and memory read data hold, and i_in.ready drops until the result
// is taken.
module record_ring_with_snapshot_policy_unit #(
    parameter int DEPTH        = 1024,
    parameter int RECORD_WIDTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrsp_in_if.sink      i_in,
    rrsp_out_if.source   o_out,
    rrsp_cfg_if.sink     i_cfg
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = rrsp_pkg::CNT_W;
    localparam int SUM_W = rrsp_pkg::CNT_W + 1;
    localparam int TIME_W = rrsp_pkg::TIME_W;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // head plus offset never reaches twice the depth where it is used
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return t[IDX_W-1:0];
    endfunction

    // configuration
    logic              r_drop_oldest;
    logic [TIME_W-1:0] r_interval;

    // ring and policy state
    logic [IDX_W-1:0]  r_head,       n_head;
    logic [CNT_W-1:0]  r_live,       n_live;
    logic              r_changed,    n_changed;
    logic              r_exists,     n_exists;
    logic [TIME_W-1:0] r_fill_start, n_fill_start;
    logic [TIME_W-1:0] r_last_snap,  n_last_snap;
    logic              r_last_valid, n_last_valid;

    // result register
    logic              r_valid;
    logic              r_ok,   n_ok;
    logic              r_peek, n_peek;
    logic [CNT_W-1:0]  r_fill;
    rrsp_pkg::t_act    r_act,  n_act;

    logic              accept;
    rrsp_pkg::t_op     op;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [RECORD_WIDTH-1:0] rd_data;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] since_snap;
    logic              aged;
    logic              due;

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign op         = rrsp_pkg::t_op'(i_in.operation);

    assign age        = i_in.now_ms - r_fill_start;
    assign since_snap = i_in.now_ms - r_last_snap;
    assign aged       = age >= r_interval;
    assign due        = !r_last_valid || (since_snap >= r_interval);

    always_comb begin
        n_head       = r_head;
        n_live       = r_live;
        n_changed    = r_changed;
        n_exists     = r_exists;
        n_fill_start = r_fill_start;
        n_last_snap  = r_last_snap;
        n_last_valid = r_last_valid;
        n_ok         = 1'b0;
        n_peek       = 1'b0;
        n_act        = rrsp_pkg::ACT_NONE;
        wr_en        = 1'b0;
        wr_addr      = wrap_idx(SUM_W'(r_head) + SUM_W'(r_live));
        rd_addr      = wrap_idx(SUM_W'(r_head) + SUM_W'(i_in.offset));
        case (op)
            rrsp_pkg::OP_PUSH: begin
                if (r_live >= DEPTH_C) begin
                    if (r_drop_oldest) begin
                        // evict oldest: the freed slot takes the new record
                        n_head    = wrap_idx(SUM_W'(r_head) + SUM_W'(1));
                        wr_en     = 1'b1;
                        wr_addr   = r_head;
                        n_ok      = 1'b1;
                        n_changed = 1'b1;
                    end
                end else begin
                    if (r_live == '0) begin
                        n_fill_start = i_in.now_ms;
                    end
                    wr_en     = 1'b1;
                    n_live    = r_live + CNT_W'(1);
                    n_ok      = 1'b1;
                    n_changed = 1'b1;
                end
            end
            rrsp_pkg::OP_PEEK: begin
                if (i_in.offset < r_live) begin
                    n_ok   = 1'b1;
                    n_peek = 1'b1;
                end
            end
            rrsp_pkg::OP_POP: begin
                if (i_in.offset >= r_live) begin
                    n_head       = '0;
                    n_live       = '0;
                    n_fill_start = '0;
                end else begin
                    n_head = rd_addr;
                    n_live = r_live - i_in.offset;
                end
                n_changed = 1'b1;
            end
            rrsp_pkg::OP_CLEAR: begin
                n_head       = '0;
                n_live       = '0;
                n_fill_start = '0;
                n_changed    = 1'b1;
            end
            rrsp_pkg::OP_MAINTAIN: begin
                if (r_live == '0) begin
                    if (r_exists) begin
                        n_act     = rrsp_pkg::ACT_REMOVE;
                        n_exists  = 1'b0;
                        n_changed = 1'b0;
                    end
                end else if (aged && due && r_changed) begin
                    n_act        = rrsp_pkg::ACT_WRITE;
                    n_exists     = 1'b1;
                    n_last_snap  = i_in.now_ms;
                    n_last_valid = 1'b1;
                    n_changed    = 1'b0;
                end
            end
            rrsp_pkg::OP_FLUSH: begin
                if (r_live != '0) begin
                    n_act        = rrsp_pkg::ACT_WRITE;
                    n_exists     = 1'b1;
                    n_last_snap  = i_in.now_ms;
                    n_last_valid = 1'b1;
                    n_changed    = 1'b0;
                end else if (r_exists) begin
                    n_act    = rrsp_pkg::ACT_REMOVE;
                    n_exists = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_oldest <= rrsp_pkg::DROP_OLDEST_RST;
            r_interval    <= rrsp_pkg::FLUSH_INTERVAL_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                rrsp_pkg::CFG_DROP_OLDEST:    r_drop_oldest <= i_cfg.data[0];
                rrsp_pkg::CFG_FLUSH_INTERVAL: r_interval    <= i_cfg.data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_live       <= '0;
            r_changed    <= 1'b0;
            r_exists     <= 1'b0;
            r_fill_start <= '0;
            r_last_snap  <= '0;
            r_last_valid <= 1'b0;
        end else if (accept) begin
            r_head       <= n_head;
            r_live       <= n_live;
            r_changed    <= n_changed;
            r_exists     <= n_exists;
            r_fill_start <= n_fill_start;
            r_last_snap  <= n_last_snap;
            r_last_valid <= n_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok   <= n_ok;
            r_peek <= n_peek;
            r_fill <= n_live;
            r_act  <= n_act;
        end
    end

    rrsp_store #(
        .DEPTH (DEPTH),
        .WIDTH (RECORD_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.record[RECORD_WIDTH-1:0]),
        .i_rd_en   (accept && n_peek),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out.valid           = r_valid;
    assign o_out.ok              = r_ok;
    assign o_out.read_record     = r_peek ? rrsp_pkg::REC_PORT_W'(rd_data) : '0;
    assign o_out.fill_count      = r_fill;
    assign o_out.snapshot_action = r_act;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= DEPTH_C)
        else $error("live count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_head) < DEPTH_S)
        else $error("head index out of range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid && (r_fill == r_live))
        else $error("result missing or fill count off after accept");

    a_write_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_act == rrsp_pkg::ACT_WRITE) |-> r_fill != '0)
        else $error("write snapshot on empty ring");

    a_remove_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_act == rrsp_pkg::ACT_REMOVE) |-> r_fill == '0)
        else $error("remove snapshot on non-empty ring");

endmodule

// ===== tb/tb_record_ring_with_snapshot_policy_unit.sv =====
module tb_record_ring_with_snapshot_policy_unit;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = 10;
    localparam int OP_W       = rrsp_pkg::OP_W;
    localparam int REC_PORT_W = rrsp_pkg::REC_PORT_W;
    localparam int CNT_W      = rrsp_pkg::CNT_W;
    localparam int TIME_W     = rrsp_pkg::TIME_W;
    localparam int ACT_W      = rrsp_pkg::ACT_W;
    localparam int CFG_IDX_W  = rrsp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rrsp_pkg::CFG_DATA_W;

    // operation and register codes the block has to ignore
    localparam logic [OP_W-1:0]      OP_SPARE_A  = 3'd6;
    localparam logic [OP_W-1:0]      OP_SPARE_B  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX    = '1;

    typedef struct packed {
        logic                  ok;
        logic [REC_PORT_W-1:0] read_record;
        logic [CNT_W-1:0]      fill_count;
        logic [ACT_W-1:0]      snapshot_action;
    } t_ring_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    rrsp_in_if  in_if ();
    rrsp_out_if out_if ();
    rrsp_cfg_if cfg_if ();

    record_ring_with_snapshot_policy_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // ring model
    logic [REC_PORT_W-1:0] ring_mem [DEPTH];
    logic [IDX_W-1:0]      ring_head;
    logic [CNT_W-1:0]      ring_count;
    logic                  dirty;
    logic                  snap_present;
    logic                  snap_time_valid;
    logic [TIME_W-1:0]     fill_start_ms;
    logic [TIME_W-1:0]     snap_time_ms;
    logic                  mode_drop_oldest;
    logic [TIME_W-1:0]     interval_ms;

    t_ring_result expected_results[$];

    logic [TIME_W-1:0] clock_ms = '0;
    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;

    int mismatches       = 0;
    int ops_sent         = 0;
    int results_checked  = 0;
    int reg_writes       = 0;
    int snapshot_writes  = 0;
    int snapshot_removes = 0;
    int refused_pushes   = 0;

    function automatic void record_snapshot(input logic [TIME_W-1:0] now_ms);
        snap_present    = 1'b1;
        snap_time_ms    = now_ms;
        snap_time_valid = 1'b1;
        dirty           = 1'b0;
        snapshot_writes++;
    endfunction

    function automatic t_ring_result predict_ring_op(input logic [OP_W-1:0] op,
            input logic [REC_PORT_W-1:0] rec, input logic [CNT_W-1:0] off,
            input logic [TIME_W-1:0] now_ms);
        t_ring_result      res;
        logic [IDX_W-1:0]  slot;
        logic [TIME_W-1:0] age_ms;
        logic [TIME_W-1:0] gap_ms;
        res = '0;
        case (op)
            rrsp_pkg::OP_PUSH: begin
                if (ring_count == CNT_W'(DEPTH) && !mode_drop_oldest) begin
                    refused_pushes++;
                end else begin
                    if (ring_count == CNT_W'(DEPTH)) begin
                        ring_head  = ring_head + 1'b1;
                        ring_count = ring_count - 1'b1;
                    end
                    if (ring_count == '0)
                        fill_start_ms = now_ms;
                    slot           = ring_head + ring_count[IDX_W-1:0];
                    ring_mem[slot] = rec;
                    ring_count     = ring_count + 1'b1;
                    dirty          = 1'b1;
                    res.ok         = 1'b1;
                end
            end
            rrsp_pkg::OP_PEEK: begin
                if (off < ring_count) begin
                    slot            = ring_head + off[IDX_W-1:0];
                    res.read_record = ring_mem[slot];
                    res.ok          = 1'b1;
                end
            end
            rrsp_pkg::OP_POP: begin
                if (off >= ring_count) begin
                    ring_head  = '0;
                    ring_count = '0;
                end else begin
                    ring_head  = ring_head + off[IDX_W-1:0];
                    ring_count = ring_count - off;
                end
                if (ring_count == '0)
                    fill_start_ms = '0;
                dirty = 1'b1;
            end
            rrsp_pkg::OP_CLEAR: begin
                ring_head     = '0;
                ring_count    = '0;
                fill_start_ms = '0;
                dirty         = 1'b1;
            end
            rrsp_pkg::OP_MAINTAIN: begin
                if (ring_count == '0) begin
                    if (snap_present) begin
                        res.snapshot_action = rrsp_pkg::ACT_REMOVE;
                        snap_present        = 1'b0;
                        dirty               = 1'b0;
                        snapshot_removes++;
                    end
                end else begin
                    // both ages wrap modulo 2^32
                    age_ms = now_ms - fill_start_ms;
                    gap_ms = now_ms - snap_time_ms;
                    if (age_ms >= interval_ms && dirty &&
                        (!snap_time_valid || gap_ms >= interval_ms)) begin
                        res.snapshot_action = rrsp_pkg::ACT_WRITE;
                        record_snapshot(now_ms);
                    end
                end
            end
            rrsp_pkg::OP_FLUSH: begin
                if (ring_count != '0) begin
                    res.snapshot_action = rrsp_pkg::ACT_WRITE;
                    record_snapshot(now_ms);
                end else if (snap_present) begin
                    res.snapshot_action = rrsp_pkg::ACT_REMOVE;
                    snap_present        = 1'b0;
                    snapshot_removes++;
                end
            end
            default: ;
        endcase
        res.fill_count = ring_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Leaves valid high after the beat is taken so back-to-back beats need
    // no extra NBA on valid within one step.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [REC_PORT_W-1:0] rec,
                           input logic [CNT_W-1:0] off, input logic [TIME_W-1:0] now_ms);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.record    <= rec;
        in_if.offset    <= off;
        in_if.now_ms    <= now_ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_results.push_back(predict_ring_op(op, rec, off, now_ms));
        ops_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == rrsp_pkg::CFG_DROP_OLDEST)
            mode_drop_oldest = data[0];
        else if (idx == rrsp_pkg::CFG_FLUSH_INTERVAL)
            interval_ms = data;
        reg_writes++;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset defaults: drop oldest, 300 s interval
    task automatic test_directed_ops();
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd0);
        send_op(rrsp_pkg::OP_FLUSH, '1, '1, 32'd0);
        send_op(rrsp_pkg::OP_PEEK, '0, '0, 32'd5);
        send_op(rrsp_pkg::OP_POP, '0, 11'd2047, 32'd10);
        send_op(rrsp_pkg::OP_PUSH, 64'h0, '0, 32'd1000);
        send_op(rrsp_pkg::OP_PUSH, '1, '1, 32'd1001);
        send_op(rrsp_pkg::OP_PUSH, 64'hA5A5_5A5A_0F0F_F0F0, '0, 32'd1002);
        send_op(rrsp_pkg::OP_PEEK, '0, 11'd0, 32'd1003);
        send_op(rrsp_pkg::OP_PEEK, '0, 11'd1, 32'd1003);
        send_op(rrsp_pkg::OP_PEEK, '0, 11'd2, 32'd1003);
        send_op(rrsp_pkg::OP_PEEK, '1, 11'd3, 32'd1003);
        send_op(rrsp_pkg::OP_PEEK, '0, 11'd2047, 32'd1003);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd300999);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd301000);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd301001);
        send_op(rrsp_pkg::OP_PUSH, 64'h1, '0, 32'd301002);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd600999);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd601000);
        send_op(rrsp_pkg::OP_POP, '0, 11'd0, 32'd601001);
        send_op(rrsp_pkg::OP_POP, '0, 11'd1, 32'd601002);
        send_op(rrsp_pkg::OP_FLUSH, '0, '0, 32'd601003);
        send_op(OP_SPARE_A, '1, '1, TIME_MAX);
        send_op(OP_SPARE_B, '1, '1, TIME_MAX);
        send_op(rrsp_pkg::OP_CLEAR, '0, '0, 32'd601004);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd601005);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd601006);
        send_op(rrsp_pkg::OP_PUSH, 64'h8000_0000_0000_0001, '0, 32'd601007);
        send_op(rrsp_pkg::OP_POP, '0, 11'd2047, 32'd601008);
        send_op(rrsp_pkg::OP_FLUSH, '0, '0, 32'd601009);
        send_op(rrsp_pkg::OP_FLUSH, '0, '0, 32'd601010);
    endtask

    task automatic test_full_ring();
        drain_results();
        // bit 0 clear selects refusal whatever the upper bits hold
        write_reg(rrsp_pkg::CFG_DROP_OLDEST, 32'hFFFF_FFFE);
        send_op(rrsp_pkg::OP_CLEAR, '0, '0, clock_ms);
        for (int i = 0; i < DEPTH; i++)
            send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom},
                    CNT_W'($urandom_range(0, 2047)), clock_ms + i);
        send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, clock_ms);
        send_op(rrsp_pkg::OP_PEEK, '0, CNT_W'(DEPTH - 1), clock_ms);
        send_op(rrsp_pkg::OP_PEEK, '0, CNT_W'(DEPTH), clock_ms);
        drain_results();
        // only bit 0 matters for the mode
        write_reg(rrsp_pkg::CFG_DROP_OLDEST, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++)
            send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, clock_ms);
        send_op(rrsp_pkg::OP_PEEK, '0, '0, clock_ms);
        send_op(rrsp_pkg::OP_PEEK, '0, CNT_W'(DEPTH - 1), clock_ms);
        // leaves the head two slots short of the end so later pushes wrap
        send_op(rrsp_pkg::OP_POP, '0, CNT_W'(DEPTH - 5), clock_ms);
        for (int i = 0; i < 10; i++)
            send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, clock_ms);
        for (int i = 0; i < 8; i++)
            send_op(rrsp_pkg::OP_PEEK, '0, CNT_W'($urandom_range(0, ring_count - 1)),
                    clock_ms);
    endtask

    task automatic test_snapshot_timing();
        drain_results();
        write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, 32'h40);
        send_op(rrsp_pkg::OP_CLEAR, '0, '0, 32'h0);
        send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, 32'hFFFF_FFE0);
        // fill age crosses the 2^32 wrap
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h1F);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h20);
        send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, 32'h21);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h5F);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h60);
        drain_results();
        write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, 32'h0);
        send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, 32'h100);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h100);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h100);
        send_op(rrsp_pkg::OP_POP, '0, '0, 32'h100);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'h100);
        drain_results();
        write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, TIME_MAX);
        send_op(rrsp_pkg::OP_CLEAR, '0, '0, 32'd100);
        send_op(rrsp_pkg::OP_PUSH, {$urandom, $urandom}, '0, 32'd100);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd98);
        send_op(rrsp_pkg::OP_MAINTAIN, '0, '0, 32'd99);
        send_op(rrsp_pkg::OP_FLUSH, '0, '0, 32'd101);
        send_op(rrsp_pkg::OP_CLEAR, '0, '0, 32'd102);
        send_op(rrsp_pkg::OP_FLUSH, '0, '0, 32'd103);
    endtask

    // Pushes at push_pct percent with peeks and small pops, so the ring stays populated and
    // the snapshot policy sees aged, dirty content; timestamps jump around the
    // interval boundary.
    task automatic run_traffic_phase(input int n_items, input int push_pct);
        logic [OP_W-1:0]       op;
        logic [CNT_W-1:0]      off;
        int                    pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                op = rrsp_pkg::OP_PUSH;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 32)      op = rrsp_pkg::OP_PEEK;
                else if (pick < 55) op = rrsp_pkg::OP_MAINTAIN;
                else if (pick < 70) op = rrsp_pkg::OP_POP;
                else if (pick < 84) op = rrsp_pkg::OP_FLUSH;
                else if (pick < 88) op = rrsp_pkg::OP_CLEAR;
                else if (pick < 90) op = OP_SPARE_A;
                else if (pick < 92) op = OP_SPARE_B;
                else                op = rrsp_pkg::OP_MAINTAIN;
            end
            if (ring_count != '0 && $urandom_range(0, 7) != 0) begin
                if (op == rrsp_pkg::OP_POP)
                    off = CNT_W'($urandom_range(0, 3));
                else
                    off = CNT_W'($urandom_range(0, ring_count - 1));
            end else begin
                off = CNT_W'($urandom_range(0, 2047));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: clock_ms = clock_ms + $urandom_range(0, 50);
                4, 5:       clock_ms = clock_ms + interval_ms - $urandom_range(0, 2);
                6, 7:       clock_ms = clock_ms + interval_ms + $urandom_range(0, 2);
                8:          clock_ms = $urandom;
                default: ;
            endcase
            send_op(op, {$urandom, $urandom}, off, clock_ms);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(rrsp_pkg::CFG_DROP_OLDEST, 32'h0);
                    write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, 32'd1);
                    run_traffic_phase(30, 80);
                end
                1: begin
                    write_reg(rrsp_pkg::CFG_DROP_OLDEST, 32'h1);
                    write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, 32'd0);
                    write_reg(CFG_SPARE_A, $urandom);
                    run_traffic_phase(30, 50);
                end
                2: begin
                    write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, TIME_MAX);
                    write_reg(CFG_SPARE_B, $urandom);
                    run_traffic_phase(30, 45);
                end
                3: begin
                    write_reg(rrsp_pkg::CFG_DROP_OLDEST, 32'h0);
                    write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, 32'd1000);
                    run_traffic_phase(30, 40);
                end
                default: begin
                    // closing stretch runs at full rate on both sides
                    idle_on  = 1'b0;
                    stall_on = 1'b0;
                    write_reg(rrsp_pkg::CFG_DROP_OLDEST, $urandom);
                    write_reg(rrsp_pkg::CFG_FLUSH_INTERVAL, $urandom_range(1, 100000));
                    run_traffic_phase(30, 50);
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_ring_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, fill_count %0d",
                                          out_if.fill_count));
            end else begin
                want = expected_results.pop_front();
                if (out_if.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", out_if.ok, want.ok));
                if (out_if.read_record !== want.read_record)
                    report_mismatch($sformatf("read_record %h, want %h",
                                              out_if.read_record, want.read_record));
                if (out_if.fill_count !== want.fill_count)
                    report_mismatch($sformatf("fill_count %0d, want %0d",
                                              out_if.fill_count, want.fill_count));
                if (out_if.snapshot_action !== want.snapshot_action)
                    report_mismatch($sformatf("snapshot_action %0d, want %0d",
                                              out_if.snapshot_action, want.snapshot_action));
            end
        end
    end

    // result-side backpressure in random bursts
    initial begin
        int hold;
        hold = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                if (hold == 0)
                    out_if.ready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 10);
                out_if.ready <= 1'b0;
            end
        end
    end

    initial begin
        #2000000;
        $display("run timed out with %0d results pending", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        in_if.valid     <= 1'b0;
        in_if.operation <= rrsp_pkg::OP_PUSH;
        in_if.record    <= '0;
        in_if.offset    <= '0;
        in_if.now_ms    <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= rrsp_pkg::CFG_DROP_OLDEST;
        cfg_if.data     <= '0;

        ring_head        = '0;
        ring_count       = '0;
        dirty            = 1'b0;
        snap_present     = 1'b0;
        snap_time_valid  = 1'b0;
        fill_start_ms    = '0;
        snap_time_ms     = '0;
        mode_drop_oldest = rrsp_pkg::DROP_OLDEST_RST;
        interval_ms      = rrsp_pkg::FLUSH_INTERVAL_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_full_ring();
        test_snapshot_timing();
        test_random_traffic();

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d operations through %0d register writes; %0d result beats checked.",
                 ops_sent, reg_writes, results_checked);
        $display("Snapshot writes %0d, removes %0d, refused pushes %0d, mismatches %0d.",
                 snapshot_writes, snapshot_removes, refused_pushes, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
